FILE: src/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

    localparam int DIV_BITS = 32;
    // divider: input register, one register per quotient bit, sign-fix register
    localparam int DIV_LAT  = DIV_BITS + 2;

    localparam logic [2:0] REG_PRESS_A = 3'd0;
    localparam logic [2:0] REG_PRESS_B = 3'd1;
    localparam logic [2:0] REG_TEMP_A  = 3'd2;
    localparam logic [2:0] REG_PRESS_C = 3'd3;
    localparam logic [2:0] REG_TEMP_B  = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] K_3038    = 32'd3038;
    localparam logic [31:0] K_M7357   = 32'hFFFF_E343;
    localparam logic [31:0] K_3791    = 32'd3791;
    localparam logic [31:0] PS_BASE   = 32'd50000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;

    typedef struct packed {
        logic [31:0] press_a;
        logic [31:0] press_b;
        logic [31:0] temp_a;
        logic [31:0] press_c;
        logic [31:0] temp_b;
        logic [1:0]  oss;
    } t_cal;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

endpackage
`default_nettype wire

FILE: src/barometric_pressure_compensation.sv
// Pressure and temperature compensation for a digital barometric sensor.
// Calibration words and the oversampling setting are written over the APB
// port (registers at 0x00..0x14); the user must write them only while the
// pipeline is empty, which the block does not enforce. Slave stream:
// tdata[15:0] raw temperature, tdata[34:16] raw pressure. Master stream:
// tdata[31:0] pressure in Pa, tdata[59:32] temperature in tenths of a
// degree, tuser = divide error (a divisor was zero). One transfer per cycle
// while the output is not stalled, through two bit-per-stage dividers
// (temperature correction term and pressure quotient) and ten arithmetic
// stages. The whole pipeline advances on one enable: when the output holds
// a result the receiver has not taken, every stage holds and s_axis_tready
// drops. Reset clears all valid bits and the calibration registers.
`default_nettype none
module barometric_pressure_compensation import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // pressure_pa, temperature_tenths
    output logic             m_axis_tuser,   // divide_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    typedef struct packed {
        logic [31:0] x1;
        logic [18:0] up;
    } t_side1;

    typedef struct packed {
        logic        msb;
        logic [27:0] t;
        logic        err;
    } t_side2;

    t_cal w_cal;
    logic en;

    bpc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cal(w_cal)
    );

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // calibration fields
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(w_cal.press_a[31:16]);
    assign ac2 = sx16(w_cal.press_a[15:0]);
    assign ac3 = sx16(w_cal.press_b[31:16]);
    assign ac4 = {16'd0, w_cal.press_b[15:0]};
    assign ac5 = {16'd0, w_cal.temp_a[31:16]};
    assign ac6 = {16'd0, w_cal.temp_a[15:0]};
    assign b1  = sx16(w_cal.press_c[31:16]);
    assign b2  = sx16(w_cal.press_c[15:0]);
    assign mc  = sx16(w_cal.temp_b[31:16]);
    assign md  = sx16(w_cal.temp_b[15:0]);

    // stage registers
    logic        r_s1_v;
    logic [31:0] r_s1_x1;
    logic [18:0] r_s1_up;

    t_side1      r_d1 [DIV_LAT];
    logic        r_v1 [DIV_LAT];
    t_side2      r_d2 [DIV_LAT];
    logic        r_v2 [DIV_LAT];

    logic        r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic        r_s7_v, r_s8_v, r_s9_v, r_o_v;
    logic [31:0] r_s2_b5;
    logic [27:0] r_s2_t, r_s3_t, r_s4_t, r_s5_t, r_s6_t;
    logic        r_s2_err, r_s3_err, r_s4_err, r_s5_err, r_s6_err;
    logic        r_s7_err, r_s8_err, r_s9_err, r_o_err;
    logic [18:0] r_s2_up, r_s3_up, r_s4_up, r_s5_up;
    logic [31:0] r_s3_b6, r_s3_sq;
    logic [31:0] r_s4_x1, r_s4_x2, r_s4_x1b, r_s4_x2b;
    logic [31:0] r_s5_b3, r_s5_w;
    logic [31:0] r_s6_b4, r_s6_b7;
    logic [27:0] r_s7_t, r_s8_t, r_s9_t, r_o_t;
    logic [31:0] r_s7_p, r_s8_p, r_s9_p, r_o_p;
    logic [31:0] r_s8_sq, r_s8_x2, r_s9_x1, r_s9_x2;

    // divider 1: temperature correction term
    logic [31:0] w_q1, w_q2;
    logic        w_z1, w_z2;

    bpc_div u_div_t (
        .i_clk, .i_en(en), .i_signed(1'b1),
        .i_num(mc << 11), .i_den(r_s1_x1 + md),
        .o_quo(w_q1), .o_zero(w_z1)
    );

    // divider 2: pressure quotient, numerator pre-scaled to avoid overflow
    logic [31:0] w_num2;
    assign w_num2 = r_s6_b7[31] ? r_s6_b7 : {r_s6_b7[30:0], 1'b0};

    bpc_div u_div_p (
        .i_clk, .i_en(en), .i_signed(1'b0),
        .i_num(w_num2), .i_den(r_s6_b4),
        .o_quo(w_q2), .o_zero(w_z2)
    );

    // combinational terms per stage
    logic [31:0] w_b5, w_b6, w_x3, w_b3n, w_x3b, w_ps;
    assign w_b5  = r_d1[DIV_LAT-1].x1 + w_q1;
    assign w_b6  = r_s2_b5 - B6_OFFSET;
    assign w_x3  = r_s4_x1 + r_s4_x2;
    assign w_b3n = ((mul32(ac1, 32'd4) + w_x3) << w_cal.oss) + 32'd2;
    assign w_x3b = asr32(r_s4_x1b + r_s4_x2b + 32'd2, 2);
    assign w_ps  = asr32(r_s7_p, 8);

    logic [31:0] w_t32;
    assign w_t32 = asr32(w_b5 + 32'd8, 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0; r_s4_v <= 1'b0;
            r_s5_v <= 1'b0; r_s6_v <= 1'b0; r_s7_v <= 1'b0; r_s8_v <= 1'b0;
            r_s9_v <= 1'b0; r_o_v  <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_v1[k] <= 1'b0;
                r_v2[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v <= s_axis_tvalid;
            r_v1[0] <= r_s1_v;
            r_v2[0] <= r_s6_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_v1[k] <= r_v1[k-1];
                r_v2[k] <= r_v2[k-1];
            end
            r_s2_v <= r_v1[DIV_LAT-1];
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_v2[DIV_LAT-1];
            r_s8_v <= r_s7_v;
            r_s9_v <= r_s8_v;
            r_o_v  <= r_s9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // s1: uncompensated temperature term
            r_s1_x1 <= asr32(mul32({16'd0, s_axis_tdata[15:0]} - ac6, ac5), 15);
            r_s1_up <= s_axis_tdata[34:16];

            r_d1[0] <= '{x1: r_s1_x1, up: r_s1_up};
            r_d2[0] <= '{msb: r_s6_b7[31], t: r_s6_t, err: r_s6_err};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
                r_d2[k] <= r_d2[k-1];
            end

            // s2: B5 and temperature
            r_s2_b5  <= w_b5;
            r_s2_t   <= w_t32[27:0];
            r_s2_err <= w_z1;
            r_s2_up  <= r_d1[DIV_LAT-1].up;

            // s3: B6 and its square
            r_s3_b6  <= w_b6;
            r_s3_sq  <= asr32(mul32(w_b6, w_b6), 12);
            r_s3_t   <= r_s2_t;
            r_s3_err <= r_s2_err;
            r_s3_up  <= r_s2_up;

            // s4: four products
            r_s4_x1  <= asr32(mul32(b2, r_s3_sq), 11);
            r_s4_x2  <= asr32(mul32(ac2, r_s3_b6), 11);
            r_s4_x1b <= asr32(mul32(ac3, r_s3_b6), 13);
            r_s4_x2b <= asr32(mul32(b1, r_s3_sq), 16);
            r_s4_t   <= r_s3_t;
            r_s4_err <= r_s3_err;
            r_s4_up  <= r_s3_up;

            // s5: B3 (divide by 4 toward zero) and B4 operand
            r_s5_b3  <= asr32(w_b3n + (w_b3n[31] ? 32'd3 : 32'd0), 2);
            r_s5_w   <= w_x3b + B4_BIAS;
            r_s5_t   <= r_s4_t;
            r_s5_err <= r_s4_err;
            r_s5_up  <= r_s4_up;

            // s6: B4 and B7
            r_s6_b4  <= mul32(ac4, r_s5_w) >> 15;
            r_s6_b7  <= mul32({13'd0, r_s5_up} - r_s5_b3, PS_BASE >> w_cal.oss);
            r_s6_t   <= r_s5_t;
            r_s6_err <= r_s5_err;

            // s7: first pressure
            r_s7_p   <= r_d2[DIV_LAT-1].msb ? {w_q2[30:0], 1'b0} : w_q2;
            r_s7_t   <= r_d2[DIV_LAT-1].t;
            r_s7_err <= r_d2[DIV_LAT-1].err | w_z2;

            // s8
            r_s8_sq  <= mul32(w_ps, w_ps);
            r_s8_x2  <= asr32(mul32(K_M7357, r_s7_p), 16);
            r_s8_p   <= r_s7_p;
            r_s8_t   <= r_s7_t;
            r_s8_err <= r_s7_err;

            // s9
            r_s9_x1  <= asr32(mul32(r_s8_sq, K_3038), 16);
            r_s9_x2  <= r_s8_x2;
            r_s9_p   <= r_s8_p;
            r_s9_t   <= r_s8_t;
            r_s9_err <= r_s8_err;

            // output register
            r_o_p    <= r_s9_p + asr32(r_s9_x1 + r_s9_x2 + K_3791, 4);
            r_o_t    <= r_s9_t;
            r_o_err  <= r_s9_err;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {4'd0, r_o_t, r_o_p};
    assign m_axis_tuser  = r_o_err;

endmodule
`default_nettype wire

FILE: src/bpc_regs.sv
`default_nettype none
module bpc_regs import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cal             o_cal
);

    t_cal       r_cal;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cal  = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_PRESS_A: r_cal.press_a <= pwdata;
                REG_PRESS_B: r_cal.press_b <= pwdata;
                REG_TEMP_A:  r_cal.temp_a  <= pwdata;
                REG_PRESS_C: r_cal.press_c <= pwdata;
                REG_TEMP_B:  r_cal.temp_b  <= pwdata;
                REG_OSS:     r_cal.oss     <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PRESS_A: prdata = r_cal.press_a;
            REG_PRESS_B: prdata = r_cal.press_b;
            REG_TEMP_A:  prdata = r_cal.temp_a;
            REG_PRESS_C: prdata = r_cal.press_c;
            REG_TEMP_B:  prdata = r_cal.temp_b;
            REG_OSS:     prdata = {30'd0, r_cal.oss};
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/bpc_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic                i_signed,
    input  wire logic [DIV_BITS-1:0] i_num,
    input  wire logic [DIV_BITS-1:0] i_den,
    output logic      [DIV_BITS-1:0] o_quo,
    output logic                     o_zero
);

    logic [DIV_BITS:0]   r_rem  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_quo  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_den  [DIV_BITS+1];
    logic                r_neg  [DIV_BITS+1];
    logic                r_zero [DIV_BITS+1];
    logic [DIV_BITS:0]   n_rem  [DIV_BITS];
    logic [DIV_BITS-1:0] n_quo  [DIV_BITS];
    logic [DIV_BITS-1:0] r_out;
    logic                r_out_zero;

    logic                w_nn, w_dn;

    assign w_nn = i_signed & i_num[DIV_BITS-1];
    assign w_dn = i_signed & i_den[DIV_BITS-1];

    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            logic [DIV_BITS:0]   sh;
            logic [DIV_BITS+1:0] dif;
            sh  = {r_rem[k][DIV_BITS-1:0], r_quo[k][DIV_BITS-1]};
            dif = {1'b0, sh} - {2'b00, r_den[k]};
            n_rem[k] = dif[DIV_BITS+1] ? sh : dif[DIV_BITS:0];
            n_quo[k] = {r_quo[k][DIV_BITS-2:0], ~dif[DIV_BITS+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= w_nn ? (~i_num + 1'b1) : i_num;
            r_den[0]  <= w_dn ? (~i_den + 1'b1) : i_den;
            r_neg[0]  <= w_nn ^ w_dn;
            r_zero[0] <= (i_den == '0);
            for (int k = 0; k < DIV_BITS; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_quo[k+1]  <= n_quo[k];
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
            end
            r_out_zero <= r_zero[DIV_BITS];
            if (r_zero[DIV_BITS]) begin
                r_out <= '0;
            end else if (r_neg[DIV_BITS]) begin
                r_out <= ~r_quo[DIV_BITS] + 1'b1;
            end else begin
                r_out <= r_quo[DIV_BITS];
            end
        end
    end

    assign o_quo  = r_out;
    assign o_zero = r_out_zero;

endmodule
`default_nettype wire

FILE: src/bpc_checker.sv
`default_nettype none
module bpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result present right after reset");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
`default_nettype wire

FILE: test/barometric_pressure_compensation_checker.sv
`timescale 1ns / 1ps
module barometric_pressure_compensation_checker import bpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // raw_temperature, raw_pressure
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,   // pressure_pa, temperature_tenths
    input  wire logic        m_axis_tuser,   // divide_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count,
    output int               o_div_err_count
);

    typedef struct packed {
        logic [31:0] pressure;
        logic [27:0] temp;
        logic        div_err;
    } t_reading;

    logic [31:0] cal_press_a, cal_press_b, cal_temp_a, cal_press_c, cal_temp_b;
    logic [1:0]  cal_oss;
    t_reading    expected_readings[$];

    function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
        shr_s = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] half_sx(input logic [15:0] v);
        half_sx = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d,
                                              inout logic err);
        logic [31:0] mn, mdv, q;
        mn  = n[31] ? -n : n;
        mdv = d[31] ? -d : d;
        if (d == 32'd0) begin
            err = 1'b1;
            div_trunc = 32'd0;
        end else begin
            q = mn / mdv;
            div_trunc = (n[31] != d[31]) ? -q : q;
        end
    endfunction

    function automatic t_reading compensate(input logic [15:0] ut, input logic [18:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t;
        logic [63:0] wide;
        logic        err;
        t_reading    r;
        ac1 = half_sx(cal_press_a[31:16]);
        ac2 = half_sx(cal_press_a[15:0]);
        ac3 = half_sx(cal_press_b[31:16]);
        ac4 = {16'd0, cal_press_b[15:0]};
        ac5 = {16'd0, cal_temp_a[31:16]};
        ac6 = {16'd0, cal_temp_a[15:0]};
        b1  = half_sx(cal_press_c[31:16]);
        b2  = half_sx(cal_press_c[15:0]);
        mc  = half_sx(cal_temp_b[31:16]);
        md  = half_sx(cal_temp_b[15:0]);
        err = 1'b0;
        x1 = shr_s(({16'd0, ut} - ac6) * ac5, 15);
        x2 = div_trunc(mc << 11, x1 + md, err);
        b5 = x1 + x2;
        t  = shr_s(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * sq, 11);
        x2 = shr_s(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4, err);
        x1 = shr_s(ac3 * b6, 13);
        x2 = shr_s(b1 * sq, 16);
        x3 = shr_s(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> cal_oss);
        if (b4 == 32'd0) begin
            err = 1'b1;
            p = 32'd0;
        end else if (!b7[31]) begin
            p = (b7 * 32'd2) / b4;
        end else begin
            p = (b7 / b4) * 32'd2;
        end
        x1 = shr_s(p, 8) * shr_s(p, 8);
        x1 = shr_s(x1 * 32'd3038, 16);
        x2 = shr_s(32'hFFFF_E343 * p, 16);
        p  = p + shr_s(x1 + x2 + 32'd3791, 4);
        r.pressure = p;
        r.temp     = t[27:0];
        r.div_err  = err;
        compensate = r;
    endfunction

    assign o_pending = expected_readings.size();

    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            cal_press_a <= '0; cal_press_b <= '0; cal_temp_a <= '0;
            cal_press_c <= '0; cal_temp_b <= '0; cal_oss <= '0;
            o_fail_count <= 0;
            o_result_count <= 0;
            o_div_err_count <= 0;
            expected_readings.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_PRESS_A: cal_press_a <= pwdata;
                    REG_PRESS_B: cal_press_b <= pwdata;
                    REG_TEMP_A:  cal_temp_a  <= pwdata;
                    REG_PRESS_C: cal_press_c <= pwdata;
                    REG_TEMP_B:  cal_temp_b  <= pwdata;
                    REG_OSS:     cal_oss     <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(compensate(s_axis_tdata[15:0],
                                                       s_axis_tdata[34:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.pressure = m_axis_tdata[31:0];
                got.temp     = m_axis_tdata[59:32];
                got.div_err  = m_axis_tuser;
                o_result_count <= o_result_count + 1;
                if (got.div_err) o_div_err_count <= o_div_err_count + 1;
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result p=%h t=%h err=%b", $time,
                             got.pressure, got.temp, got.div_err);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_readings.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected p=%h t=%h err=%b actual p=%h t=%h err=%b",
                                 $time, want.pressure, want.temp, want.div_err,
                                 got.pressure, got.temp, got.div_err);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: test/barometric_pressure_compensation_test.sv
`timescale 1ns / 1ps
module barometric_pressure_compensation_test import bpc_pkg::*;;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, result_count, div_err_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_recv = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    barometric_pressure_compensation dut (.*);

    barometric_pressure_compensation_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_div_err_count(div_err_count)
    );

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // tvalid stays up after a transfer so the next item can follow at once
    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, up, ut};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // wait out everything in flight, including the pipeline tail
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DIV_LAT * 3 + 20) @(posedge i_clk);
    endtask

    // realistic datasheet-like calibration, or fully random words
    task automatic load_cal(input bit typical, input logic [1:0] oss);
        if (typical) begin
            reg_write(REG_PRESS_A, {16'd408, 16'hFFC8});
            reg_write(REG_PRESS_B, {16'hC69E, 16'd32741});
            reg_write(REG_TEMP_A, {16'd32757, 16'd23153});
            reg_write(REG_PRESS_C, {16'd6190, 16'd4});
            reg_write(REG_TEMP_B, {16'h D4BD, 16'd2868});
        end else begin
            reg_write(REG_PRESS_A, $urandom);
            reg_write(REG_PRESS_B, $urandom);
            reg_write(REG_TEMP_A, $urandom);
            reg_write(REG_PRESS_C, $urandom);
            reg_write(REG_TEMP_B, $urandom);
        end
        reg_write(REG_OSS, {30'd0, oss});
    endtask

    task automatic random_reading(input bit typical);
        if (typical)
            send_reading(16'd27898 + 16'($urandom_range(4000)) - 16'd2000,
                         19'($urandom_range(30000, 50000)));
        else
            send_reading(16'($urandom), 19'($urandom));
    endtask

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int phase, k, n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_idle_pct = 0;

        // all-zero calibration: every divisor zero
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        drain();
        load_cal(1'b1, 2'd0);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'd23153, 19'd40000);
        drain();
        // x1+md zero: ac5=0 makes x1 0, md=0
        reg_write(REG_TEMP_A, 32'h0000_1234);
        reg_write(REG_TEMP_B, 32'h8000_0000);
        send_reading(16'd100, 19'd30000);
        drain();
        reg_write(REG_TEMP_B, 32'h7FFF_FFFF);
        send_reading(16'd100, 19'd30000);
        drain();
        // extreme calibration words
        for (k = 0; k < 4; k++) begin
            reg_write(REG_PRESS_A, k[0] ? 32'h8000_8000 : 32'h7FFF_7FFF);
            reg_write(REG_PRESS_B, k[1] ? 32'h8000_FFFF : 32'h7FFF_0001);
            reg_write(REG_TEMP_A, k[0] ? 32'hFFFF_FFFF : 32'h0001_0000);
            reg_write(REG_PRESS_C, k[1] ? 32'h7FFF_8000 : 32'h8000_7FFF);
            reg_write(REG_TEMP_B, k[0] ? 32'h8000_FFFF : 32'h7FFF_0001);
            reg_write(REG_OSS, 32'(k));
            send_reading(16'd0, 19'h7FFFF);
            send_reading(16'hFFFF, 19'd0);
            send_reading(16'h8000, 19'h40000);
            drain();
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 22 : 0;
            for (k = 0; k < 4; k++) begin
                load_cal(k != 3, 2'(k + phase));
                n = (phase == 2) ? 130 : 125;
                for (int j = 0; j < n; j++)
                    random_reading((k != 3) && ($urandom_range(9) != 0));
                // sender pause until all results are back
                drain();
            end
        end

        // long receiver hold-off while items keep coming
        load_cal(1'b1, 2'd3);
        hold_recv = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (int j = 0; j < 150; j++) random_reading(1'b1);
        join
        drain();

        $display("covered %0d results (%0d with a zero divisor), all oversampling modes,",
                 result_count, div_err_count);
        $display("typical, random and extreme calibration, stalls on both streams");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
